// ===== rtl/piecewise_linear_interpolator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PLI_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pli assertion failed");

`define PLI_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pli assertion failed");

`else

`define PLI_ASSERT(name, clk, rst_n, prop)

`define PLI_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Widths, codes and controller/datapath bundles shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int unsigned MaxPoints = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CntW      = 5;
  localparam int unsigned XW        = 32;
  localparam int unsigned YW        = 32;
  localparam int unsigned MagW      = 32;
  localparam int unsigned DiffW     = 33;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned DivSteps  = 34;
  localparam int unsigned QW        = DivSteps + 1;
  localparam int unsigned SumW      = QW + 1;
  localparam int unsigned StepW     = 6;
  localparam int unsigned EntryW    = XW + YW;

  localparam logic [CntW-1:0] CountMin   = 5'd2;
  localparam logic [CntW-1:0] CountMax   = 5'd16;
  localparam logic [CntW-1:0] CountReset = 5'd16;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  localparam logic [1:0] ExtInside = 2'd0;
  localparam logic [1:0] ExtBelow  = 2'd1;
  localparam logic [1:0] ExtAbove  = 2'd2;

  localparam logic [QW-1:0] QClamp = {1'b1, {DivSteps{1'b0}}};

  typedef struct packed {
    logic load;
    logic start;
    logic rd_srch;
    logic cmp;
    logic rd_lo;
    logic rd_hi;
    logic diff;
    logic mul;
    logic div_init;
    logic div_step;
    logic fin;
  } pli_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic div_last;
    logic out_free;
  } pli_sts_t;

  typedef struct packed {
    logic signed [YW-1:0] result_y;
    logic [IdxW-1:0]      segment;
    logic [1:0]           extrapolated;
    logic                 div_error;
    logic                 saturated;
  } pli_res_t;

endpackage

`default_nettype wire

// ===== rtl/pli_in_if.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator request channel
// Valid/ready channel carrying load and query requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [pli_pkg::IdxW-1:0]      index;
  logic [pli_pkg::XW-1:0]        x_value;
  logic signed [pli_pkg::YW-1:0] y_value;

  modport source (output valid, output mode, output index, output x_value,
                  output y_value, input ready);
  modport sink (input valid, input mode, input index, input x_value,
                input y_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/pli_out_if.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator result channel
// Valid/ready channel carrying one result per query request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [pli_pkg::YW-1:0] result_y;
  logic [pli_pkg::IdxW-1:0]      segment;
  logic [1:0]                    extrapolated;
  logic                          div_error;
  logic                          saturated;

  modport source (output valid, output result_y, output segment,
                  output extrapolated, output div_error, output saturated,
                  input ready);
  modport sink (input valid, input result_y, input segment, input extrapolated,
                input div_error, input saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/pli_ctrl.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator controller
// Sequences search, operand fetch, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "piecewise_linear_interpolator_unit_assert.svh"

module pli_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  input  pli_pkg::pli_sts_t sts,
  output pli_pkg::pli_cmd_t cmd
);
  import pli_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRD   = 10'b0000000010,
    S_SCMP  = 10'b0000000100,
    S_RLO   = 10'b0000001000,
    S_RHI   = 10'b0000010000,
    S_DIFF  = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_DINIT = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } pli_state_t;

  pli_state_t state_r;
  pli_state_t state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = accept && (in_mode == ModeLoad);
    cmd.start    = accept && (in_mode == ModeQuery);
    cmd.rd_srch  = (state_r == S_SRD);
    cmd.cmp      = (state_r == S_SCMP);
    cmd.rd_lo    = (state_r == S_RLO);
    cmd.rd_hi    = (state_r == S_RHI);
    cmd.diff     = (state_r == S_DIFF);
    cmd.mul      = (state_r == S_MUL);
    cmd.div_init = (state_r == S_DINIT);
    cmd.div_step = (state_r == S_DIV);
    cmd.fin      = (state_r == S_FIN) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == ModeQuery)) state_nxt = S_SRD;
      end
      S_SRD:   state_nxt = S_SCMP;
      S_SCMP: begin
        state_nxt = sts.srch_done ? S_RLO : S_SRD;
      end
      S_RLO:   state_nxt = S_RHI;
      S_RHI:   state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DINIT;
      S_DINIT: state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PLI_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> state_r == S_IDLE)
  `PLI_ASSERT(a_fin_after_div, clk, rst_n,
              state_r == S_FIN |-> $past(state_r) == S_DIV || $past(state_r) == S_FIN)
  `PLI_ASSERT(a_no_accept_busy, clk, rst_n,
              state_r != S_IDLE |-> !cmd.load && !cmd.start)

endmodule

`default_nettype wire

// ===== rtl/pli_dp.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator datapath
// Breakpoint memory, search counter, multiplier, restoring divider, output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "piecewise_linear_interpolator_unit_assert.svh"

module pli_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pli_pkg::CntW-1:0]      cfg_data,
  input  pli_pkg::pli_cmd_t             cmd,
  output pli_pkg::pli_sts_t             sts,
  input  logic [pli_pkg::IdxW-1:0]      in_index,
  input  logic [pli_pkg::XW-1:0]        in_x_value,
  input  logic signed [pli_pkg::YW-1:0] in_y_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output pli_pkg::pli_res_t             out_res
);
  import pli_pkg::*;

  logic [EntryW-1:0]      mem [MaxPoints];
  logic [EntryW-1:0]      mem_q_r;
  logic [CntW-1:0]        count_r;
  logic [CntW-1:0]        n_eff;
  logic [CntW-1:0]        n_r;
  logic [CntW-1:0]        i_r;
  logic [XW-1:0]          xq_r;
  logic [XW-1:0]          x0_r;
  logic [YW-1:0]          y0_r;
  logic                   x_lt;
  logic                   at_first;
  logic                   at_end;
  logic [CntW-1:0]        lo_idx;
  logic [CntW-1:0]        hi_idx;
  logic [IdxW-1:0]        rd_addr;
  logic [XW-1:0]          x1;
  logic [YW-1:0]          y1;
  logic [DiffW-1:0]       num_s;
  logic [DiffW-1:0]       den_s;
  logic [DiffW-1:0]       dy_s;
  logic [DiffW-1:0]       num_n;
  logic [DiffW-1:0]       den_n;
  logic [DiffW-1:0]       dy_n;
  logic [MagW-1:0]        num_mag_r;
  logic [MagW-1:0]        den_mag_r;
  logic [MagW-1:0]        dy_mag_r;
  logic                   neg_r;
  logic                   den_zero_r;
  logic [1:0]             ext_r;
  logic [IdxW-1:0]        seg_r;
  logic [ProdW-1:0]       prod_r;
  logic [MagW-1:0]        rem_r;
  logic [DivSteps-1:0]    dq_r;
  logic                   ovf_r;
  logic [StepW-1:0]       step_r;
  logic [MagW-1:0]        rem_init;
  logic [MagW:0]          trial;
  logic [MagW:0]          trial_sub;
  logic                   trial_ge;
  logic [QW-1:0]          q;
  logic [SumW-1:0]        y0_ext;
  logic [SumW-1:0]        q_ext;
  logic [SumW-1:0]        sum;
  logic                   sat_nxt;
  pli_res_t               res_nxt;
  logic                   out_valid_r;
  pli_res_t               out_q_r;

  always_comb begin
    if (count_r < CountMin) begin
      n_eff = CountMin;
    end else if (count_r > CountMax) begin
      n_eff = CountMax;
    end else begin
      n_eff = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CountReset;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end
  end

  assign x_lt     = mem_q_r[EntryW-1:YW] < xq_r;
  assign at_first = (i_r == '0);
  assign at_end   = (i_r == n_r);

  always_comb begin
    if (at_first) begin
      lo_idx = '0;
      hi_idx = CntW'(1);
    end else if (at_end) begin
      lo_idx = n_r - CntW'(1);
      hi_idx = n_r - CntW'(2);
    end else begin
      lo_idx = i_r - CntW'(1);
      hi_idx = i_r;
    end
  end

  always_comb begin
    if (cmd.rd_srch) begin
      rd_addr = i_r[IdxW-1:0];
    end else if (cmd.rd_lo) begin
      rd_addr = lo_idx[IdxW-1:0];
    end else begin
      rd_addr = hi_idx[IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[in_index] <= {in_x_value, in_y_value};
    end
    if (cmd.rd_srch || cmd.rd_lo || cmd.rd_hi) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      n_r <= CountMin;
    end else if (cmd.start) begin
      i_r <= '0;
      n_r <= n_eff;
    end else if (cmd.cmp && x_lt) begin
      i_r <= i_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      xq_r <= in_x_value;
    end
    if (cmd.rd_hi) begin
      x0_r <= mem_q_r[EntryW-1:YW];
      y0_r <= mem_q_r[YW-1:0];
    end
  end

  assign x1    = mem_q_r[EntryW-1:YW];
  assign y1    = mem_q_r[YW-1:0];
  assign num_s = {1'b0, xq_r} - {1'b0, x0_r};
  assign den_s = {1'b0, x1} - {1'b0, x0_r};
  assign dy_s  = {y1[YW-1], y1} - {y0_r[YW-1], y0_r};
  assign num_n = '0 - num_s;
  assign den_n = '0 - den_s;
  assign dy_n  = '0 - dy_s;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      num_mag_r  <= num_s[DiffW-1] ? num_n[MagW-1:0] : num_s[MagW-1:0];
      den_mag_r  <= den_s[DiffW-1] ? den_n[MagW-1:0] : den_s[MagW-1:0];
      dy_mag_r   <= dy_s[DiffW-1] ? dy_n[MagW-1:0] : dy_s[MagW-1:0];
      neg_r      <= dy_s[DiffW-1] ^ num_s[DiffW-1] ^ den_s[DiffW-1];
      den_zero_r <= (den_s == '0);
      seg_r      <= at_end ? hi_idx[IdxW-1:0] : lo_idx[IdxW-1:0];
      if (at_first) begin
        ext_r <= num_s[DiffW-1] ? ExtBelow : ExtInside;
      end else if (at_end) begin
        ext_r <= ExtAbove;
      end else begin
        ext_r <= ExtInside;
      end
    end
    if (cmd.mul) begin
      prod_r <= dy_mag_r * num_mag_r;
    end
  end

  assign rem_init  = {{(MagW - ProdW + DivSteps){1'b0}}, prod_r[ProdW-1:DivSteps]};
  assign trial     = {rem_r, dq_r[DivSteps-1]};
  assign trial_sub = trial - {1'b0, den_mag_r};
  assign trial_ge  = trial >= {1'b0, den_mag_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= rem_init;
      dq_r   <= prod_r[DivSteps-1:0];
      ovf_r  <= rem_init >= den_mag_r;
      step_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? trial_sub[MagW-1:0] : trial[MagW-1:0];
      dq_r   <= {dq_r[DivSteps-2:0], trial_ge};
      step_r <= step_r + StepW'(1);
    end
  end

  assign q      = ovf_r ? QClamp : {1'b0, dq_r};
  assign y0_ext = {{(SumW - YW){y0_r[YW-1]}}, y0_r};
  assign q_ext  = {1'b0, q};
  assign sum    = neg_r ? (y0_ext - q_ext) : (y0_ext + q_ext);
  assign sat_nxt = !((sum[SumW-1:YW-1] == '0) || (sum[SumW-1:YW-1] == '1));

  always_comb begin
    res_nxt.segment      = seg_r;
    res_nxt.extrapolated = ext_r;
    res_nxt.div_error    = den_zero_r;
    if (den_zero_r) begin
      res_nxt.result_y  = '0;
      res_nxt.saturated = 1'b0;
    end else if (sat_nxt) begin
      res_nxt.result_y  = sum[SumW-1] ? {1'b1, {(YW-1){1'b0}}} : {1'b0, {(YW-1){1'b1}}};
      res_nxt.saturated = 1'b1;
    end else begin
      res_nxt.result_y  = sum[YW-1:0];
      res_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_q_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_res       = out_q_r;
  assign sts.srch_done = !x_lt || ((i_r + CntW'(1)) == n_r);
  assign sts.div_last  = (step_r == StepW'(DivSteps - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  `PLI_ASSERT(a_valid_from_fin, clk, rst_n, $rose(out_valid_r) |-> $past(cmd.fin))
  `PLI_ASSERT(a_div_error_zero, clk, rst_n,
              out_valid_r && out_q_r.div_error |-> out_q_r.result_y == '0 && !out_q_r.saturated)
  `PLI_ASSERT(a_clamp_saturates, clk, rst_n, cmd.fin |-> !ovf_r || sat_nxt || den_zero_r)
  `PLI_ASSERT(a_search_bound, clk, rst_n, i_r <= n_r)

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear interpolator unit
// A load request writes one breakpoint and gives no result. A query request
// scans the breakpoint table from entry 0, with a registered memory read and
// then a compare for each entry examined (1 up to the entry count, clamped to
// 2..16), and then goes on to operand fetch, a 32x32 multiply and a 34-step
// restoring divider. The result is loaded into the output register once that
// register is free; otherwise the final state holds until the earlier result
// is taken. The block takes its next request in the cycle after the result is
// loaded into the output register, even if that result has not yet been
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  pli_in_if.sink                   in_chan,
  pli_out_if.source                out_chan,
  input  logic                     cfg_we,
  input  logic [pli_pkg::CntW-1:0] cfg_data
);
  import pli_pkg::*;

  pli_cmd_t cmd;
  pli_sts_t sts;
  pli_res_t res;
  logic     in_ready;
  logic     out_valid;

  pli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_mode  (in_chan.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pli_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .in_index   (in_chan.index),
    .in_x_value (in_chan.x_value),
    .in_y_value (in_chan.y_value),
    .out_ready  (out_chan.ready),
    .out_valid  (out_valid),
    .out_res    (res)
  );

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid;
  assign out_chan.result_y     = res.result_y;
  assign out_chan.segment      = res.segment;
  assign out_chan.extrapolated = res.extrapolated;
  assign out_chan.div_error    = res.div_error;
  assign out_chan.saturated    = res.saturated;

endmodule

`default_nettype wire
